### rtl/drp_pkg.sv
package drp_pkg;

    localparam logic [31:0] COOKIE       = 32'h63825363;
    localparam logic [7:0]  OPT_PAD      = 8'h00;
    localparam logic [7:0]  OPT_END      = 8'hff;
    localparam logic [7:0]  OPT_MASK     = 8'h01;
    localparam logic [7:0]  OPT_ROUTER   = 8'h03;
    localparam logic [7:0]  OPT_DNS      = 8'h06;
    localparam logic [7:0]  OPT_REQ_ADDR = 8'h32;
    localparam logic [7:0]  OPT_LEASE    = 8'h33;
    localparam logic [7:0]  OPT_MSG_TYPE = 8'h35;
    localparam logic [7:0]  OPT_SERVER   = 8'h36;

    localparam logic [7:0]  OP_REQUEST   = 8'd1;
    localparam logic [7:0]  MT_DISCOVER  = 8'd1;
    localparam logic [7:0]  MT_REQUEST   = 8'd3;
    localparam logic [7:0]  REPLY_NONE   = 8'd0;
    localparam logic [7:0]  REPLY_OFFER  = 8'd2;
    localparam logic [7:0]  REPLY_ACK    = 8'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int RESULT_W = 304;

    typedef enum logic [2:0] {
        K_IGNORE     = 3'd0,
        K_OP         = 3'd1,
        K_XID        = 3'd2,
        K_HW         = 3'd3,
        K_COOKIE     = 3'd4,
        K_COOKIE_END = 3'd5,
        K_OPT        = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } queue_entry_t;

    typedef struct packed {
        logic [7:0]  reply_type;
        logic        magic_ok;
        logic [7:0]  message_type;
        logic [31:0] transaction_id;
        logic [47:0] client_hw_addr;
        logic [31:0] requested_addr;
        logic [31:0] server_id;
        logic [31:0] lease_seconds;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
        logic [7:0]  op_code;
    } result_t;

endpackage

### rtl/dhcp_request_parser.sv
// DHCP request parser.
// Input channel (s_*): one byte of the UDP payload per beat, s_tlast on the
// final byte of each message. Output channel (m_*): one result beat per
// message with the captured header fields, the option values, the cookie
// flag and the reply type.
// The front classifies each byte by its offset and writes it into a
// four-entry queue; the back runs the cookie check and the option walk at
// one byte per cycle. Throughput is one byte per cycle, set by the single
// byte the back consumes each cycle, while no closing byte waits for a
// busy output register. With the queue empty, the final byte is written
// into the queue and then, as it leaves, lands in the output register,
// which raises m_tvalid; bytes still queued ahead of it leave first.
// When m_tready is low a finished result waits in the output register while
// bytes of the next message keep flowing into the back; only the closing
// byte of the next message waits, and s_tready drops once the queue fills.
// Reset clears the byte counter, the queue and all captured fields; every
// emitted result also clears the parser for the next message.
module dhcp_request_parser import drp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 300
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic                s_tlast,   // last_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // reply_type, magic_ok, message_type, transaction_id, client_hw_addr,
    // requested_addr, server_id, lease_seconds, subnet_mask, router_addr,
    // dns_addr, op_code, then zero fill
    output logic [RESULT_W-1:0] m_tdata
);

    logic         push;
    logic         pop;
    logic         empty;
    logic         full;
    queue_entry_t push_entry;
    queue_entry_t head_entry;
    result_t      result;

    drp_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    drp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (empty),
        .full       (full)
    );

    drp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {7'd0, result.op_code, result.dns_addr, result.router_addr,
                      result.subnet_mask, result.lease_seconds, result.server_id,
                      result.requested_addr, result.client_hw_addr,
                      result.transaction_id, result.message_type, result.magic_ok,
                      result.reply_type};

endmodule

### rtl/drp_front.sv
module drp_front import drp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 300
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         queue_full,
    output logic         push,
    output queue_entry_t push_entry
);

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    kind_t            kind;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Classify each byte purely by its offset in the message.
    always_comb
    begin
        kind = K_IGNORE;
        if (pos_reg >= POS_W'(MAX_MESSAGE_BYTES))
            kind = K_IGNORE;
        else if (pos_reg == POS_W'(0))
            kind = K_OP;
        else if (pos_reg >= POS_W'(4) && pos_reg <= POS_W'(7))
            kind = K_XID;
        else if (pos_reg >= POS_W'(28) && pos_reg <= POS_W'(33))
            kind = K_HW;
        else if (pos_reg >= POS_W'(236) && pos_reg <= POS_W'(238))
            kind = K_COOKIE;
        else if (pos_reg == POS_W'(239))
            kind = K_COOKIE_END;
        else if (pos_reg >= POS_W'(240))
            kind = K_OPT;
    end

    assign push_entry.kind = kind;
    assign push_entry.data = s_tdata;
    assign push_entry.last = s_tlast;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (s_tlast)
                pos_next = '0;
            else if (pos_reg < POS_W'(MAX_MESSAGE_BYTES))
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

### rtl/drp_queue.sv
module drp_queue import drp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head_entry,
    output logic         empty,
    output logic         full
);

    queue_entry_t       mem_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QAW:0]       count_reg;
    logic [QAW:0]       count_next;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QAW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QAW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("push into a full queue");

endmodule

### rtl/drp_back.sv
module drp_back import drp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  queue_entry_t head_entry,
    input  logic         empty,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_result
);

    typedef enum logic [2:0] {
        PH_CODE  = 3'b001,
        PH_LEN   = 3'b010,
        PH_VALUE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0]  op;
        logic [7:0]  mt;
        logic        magic;
        logic [31:0] cookie;
        logic [31:0] xid;
        logic [47:0] hw;
        logic [31:0] req;
        logic [31:0] srv;
        logic [31:0] lease;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
    } cap_t;

    cap_t        cap_reg, cap_next, cap_upd;
    phase_t      phase_reg, phase_next, phase_upd;
    logic [7:0]  code_reg, code_next, code_upd;
    logic [7:0]  left_reg, left_next, left_upd;
    logic [31:0] vs_reg, vs_next, vs_upd;
    logic [2:0]  vc_reg, vc_next, vc_upd;
    logic        done_reg, done_next, done_upd;
    logic        out_valid_reg;
    result_t     out_result_reg;
    logic [31:0] cookie_sh;
    logic [7:0]  first_byte;
    logic [7:0]  reply;
    logic        finish;

    // A closing beat needs a free output slot; other beats always drain.
    assign pop    = !empty && (!head_entry.last || !out_valid_reg || out_ready);
    assign finish = pop && head_entry.last;

    always_comb
    begin
        cap_upd   = cap_reg;
        phase_upd = phase_reg;
        code_upd  = code_reg;
        left_upd  = left_reg;
        vs_upd    = vs_reg;
        vc_upd    = vc_reg;
        done_upd  = done_reg;
        cookie_sh = {cap_reg.cookie[23:0], head_entry.data};
        first_byte = 8'd0;
        case (head_entry.kind)
            K_OP:
                cap_upd.op = head_entry.data;
            K_XID:
                cap_upd.xid = {cap_reg.xid[23:0], head_entry.data};
            K_HW:
                cap_upd.hw = {cap_reg.hw[39:0], head_entry.data};
            K_COOKIE:
                cap_upd.cookie = cookie_sh;
            K_COOKIE_END:
            begin
                cap_upd.cookie = cookie_sh;
                if (cookie_sh == COOKIE)
                    cap_upd.magic = 1'b1;
            end
            K_OPT:
            begin
                if (cap_reg.magic && !done_reg)
                begin
                    case (phase_reg)
                        PH_CODE:
                        begin
                            if (head_entry.data == OPT_END)
                                done_upd = 1'b1;
                            else if (head_entry.data != OPT_PAD)
                            begin
                                code_upd  = head_entry.data;
                                phase_upd = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            left_upd  = head_entry.data;
                            vs_upd    = 32'd0;
                            vc_upd    = 3'd0;
                            phase_upd = (head_entry.data == 8'd0) ? PH_CODE : PH_VALUE;
                        end
                        PH_VALUE:
                        begin
                            if (vc_reg < 3'd4)
                            begin
                                vs_upd = {vs_reg[23:0], head_entry.data};
                                vc_upd = vc_reg + 3'd1;
                            end
                            left_upd = left_reg - 8'd1;
                            if (left_upd == 8'd0)
                            begin
                                phase_upd = PH_CODE;
                                // The message type keeps the first value byte only.
                                case (vc_upd)
                                    3'd1:    first_byte = vs_upd[7:0];
                                    3'd2:    first_byte = vs_upd[15:8];
                                    3'd3:    first_byte = vs_upd[23:16];
                                    default: first_byte = vs_upd[31:24];
                                endcase
                                case (code_reg)
                                    OPT_MASK:     cap_upd.mask   = vs_upd;
                                    OPT_ROUTER:   cap_upd.router = vs_upd;
                                    OPT_DNS:      cap_upd.dns    = vs_upd;
                                    OPT_REQ_ADDR: cap_upd.req    = vs_upd;
                                    OPT_LEASE:    cap_upd.lease  = vs_upd;
                                    OPT_SERVER:   cap_upd.srv    = vs_upd;
                                    OPT_MSG_TYPE: cap_upd.mt     = first_byte;
                                    default:      cap_upd.mt     = cap_reg.mt;
                                endcase
                            end
                        end
                        default:
                            phase_upd = PH_CODE;
                    endcase
                end
            end
            default:
                cap_upd = cap_reg;
        endcase
    end

    always_comb
    begin
        reply = REPLY_NONE;
        if (cap_upd.op == OP_REQUEST && cap_upd.mt == MT_DISCOVER)
            reply = REPLY_OFFER;
        else if (cap_upd.op == OP_REQUEST && cap_upd.mt == MT_REQUEST)
            reply = REPLY_ACK;
    end

    always_comb
    begin
        cap_next   = cap_reg;
        phase_next = phase_reg;
        code_next  = code_reg;
        left_next  = left_reg;
        vs_next    = vs_reg;
        vc_next    = vc_reg;
        done_next  = done_reg;
        if (finish)
        begin
            cap_next   = '0;
            phase_next = PH_CODE;
            code_next  = 8'd0;
            left_next  = 8'd0;
            vs_next    = 32'd0;
            vc_next    = 3'd0;
            done_next  = 1'b0;
        end
        else if (pop)
        begin
            cap_next   = cap_upd;
            phase_next = phase_upd;
            code_next  = code_upd;
            left_next  = left_upd;
            vs_next    = vs_upd;
            vc_next    = vc_upd;
            done_next  = done_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= '0;
            phase_reg     <= PH_CODE;
            code_reg      <= 8'd0;
            left_reg      <= 8'd0;
            vs_reg        <= 32'd0;
            vc_reg        <= 3'd0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            phase_reg <= phase_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
            vs_reg    <= vs_next;
            vc_reg    <= vc_next;
            done_reg  <= done_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_result_reg.reply_type     <= reply;
            out_result_reg.magic_ok       <= cap_upd.magic;
            out_result_reg.message_type   <= cap_upd.mt;
            out_result_reg.transaction_id <= cap_upd.xid;
            out_result_reg.client_hw_addr <= cap_upd.hw;
            out_result_reg.requested_addr <= cap_upd.req;
            out_result_reg.server_id      <= cap_upd.srv;
            out_result_reg.lease_seconds  <= cap_upd.lease;
            out_result_reg.subnet_mask    <= cap_upd.mask;
            out_result_reg.router_addr    <= cap_upd.router;
            out_result_reg.dns_addr       <= cap_upd.dns;
            out_result_reg.op_code        <= cap_upd.op;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("closing beat did not produce a result");

    a_done_needs_cookie: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cap_reg.magic)
        else $error("option walk ended without a valid cookie");

endmodule

### test/dhcp_request_parser_test.sv
`timescale 1ns / 1ps

module dhcp_request_parser_test;
    import drp_pkg::*;

    localparam int MSG_LIMIT      = 300;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_LIMIT     = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 1800;

    localparam int OFS_XID        = 4;
    localparam int OFS_XID_END    = 7;
    localparam int OFS_HW         = 28;
    localparam int OFS_HW_END     = 33;
    localparam int OFS_COOKIE     = 236;
    localparam int OFS_COOKIE_END = 239;
    localparam int OFS_OPTIONS    = 240;

    // The six 32-bit options first, message type last.
    localparam logic [7:0] KEPT_CODES [7] = '{OPT_MASK, OPT_ROUTER, OPT_DNS, OPT_REQ_ADDR,
                                              OPT_LEASE, OPT_SERVER, OPT_MSG_TYPE};

    typedef enum logic [2:0] {
        WALK_CODE  = 3'b001,
        WALK_LEN   = 3'b010,
        WALK_VALUE = 3'b100
    } walk_phase_t;

    // Fields run from the top bit down, so a cast of the low bits of the beat
    // lines up with the layout of m_tdata (reply_type in the lowest byte).
    typedef struct packed {
        logic [7:0]  op_code;
        logic [31:0] dns_addr;
        logic [31:0] router_addr;
        logic [31:0] subnet_mask;
        logic [31:0] lease_seconds;
        logic [31:0] server_id;
        logic [31:0] requested_addr;
        logic [47:0] client_hw_addr;
        logic [31:0] transaction_id;
        logic [7:0]  message_type;
        logic        magic_ok;
        logic [7:0]  reply_type;
    } dhcp_summary_t;

    localparam int SUMMARY_W = $bits(dhcp_summary_t);

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_beat_t;

    typedef enum {
        CASE_FILL,
        CASE_DISCOVER,
        CASE_REQUEST,
        CASE_ALL_VALUES,
        CASE_PADS_AND_END,
        CASE_VALUE_LENGTHS,
        CASE_REPEATED,
        CASE_UNKNOWN,
        CASE_CUT_BY_LAST,
        CASE_CUT_BY_LIMIT,
        CASE_BAD_COOKIE,
        CASE_MT_LONG
    } drp_case_t;

    typedef struct {
        drp_case_t   which;
        logic [7:0]  op;
        logic [7:0]  fill;
        int          len;
        bit          typed;
        logic [31:0] t_xid;
    } directed_row_t;

    // A typed row expects op_code and transaction_id as given, every other field zero.
    directed_row_t directed_rows [23] = '{
        '{CASE_FILL,          8'h00,      8'h00, 1,   1'b1, 32'h0000_0000},
        '{CASE_FILL,          8'hff,      8'h00, 1,   1'b1, 32'h0000_0000},
        '{CASE_FILL,          8'h01,      8'h00, 3,   1'b1, 32'h0000_0000},
        '{CASE_FILL,          8'h01,      8'h01, 5,   1'b1, 32'h0000_0001},
        '{CASE_FILL,          8'hff,      8'hff, 8,   1'b1, 32'hffff_ffff},
        '{CASE_FILL,          8'h00,      8'h00, 40,  1'b1, 32'h0000_0000},
        '{CASE_DISCOVER,      OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_DISCOVER,      8'h02,      8'h00, 0,   1'b0, 32'h0},
        '{CASE_DISCOVER,      OP_REQUEST, 8'h00, 238, 1'b0, 32'h0},
        '{CASE_DISCOVER,      OP_REQUEST, 8'h00, 240, 1'b0, 32'h0},
        '{CASE_DISCOVER,      OP_REQUEST, 8'h00, 600, 1'b0, 32'h0},
        '{CASE_REQUEST,       OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_REQUEST,       8'hff,      8'h00, 0,   1'b0, 32'h0},
        '{CASE_ALL_VALUES,    OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_ALL_VALUES,    OP_REQUEST, 8'hff, 0,   1'b0, 32'h0},
        '{CASE_PADS_AND_END,  OP_REQUEST, 8'h00, 270, 1'b0, 32'h0},
        '{CASE_VALUE_LENGTHS, OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_REPEATED,      OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_UNKNOWN,       OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_CUT_BY_LAST,   OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_CUT_BY_LIMIT,  OP_REQUEST, 8'h5a, 320, 1'b0, 32'h0},
        '{CASE_BAD_COOKIE,    OP_REQUEST, 8'h00, 0,   1'b0, 32'h0},
        '{CASE_MT_LONG,       OP_REQUEST, 8'h00, 0,   1'b0, 32'h0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // data_byte
    logic                s_tlast;   // last_byte
    logic                m_tvalid;
    logic                m_tready;
    // reply_type, magic_ok, message_type, transaction_id, client_hw_addr,
    // requested_addr, server_id, lease_seconds, subnet_mask, router_addr,
    // dns_addr, op_code, then zero fill
    logic [RESULT_W-1:0] m_tdata;

    stream_beat_t  tx_q [$];
    dhcp_summary_t pending_summaries [$];
    dhcp_summary_t typed_summaries [$];
    bit            typed_present [$];

    int unsigned   bytes_queued;
    int unsigned   bytes_accepted;
    int unsigned   failures;
    int unsigned   idle_cycles;
    bit            in_taken;
    bit            long_hold_req;

    // Parser state of the predictor.
    int unsigned   p_pos;
    walk_phase_t   p_phase;
    logic [7:0]    p_code;
    logic [7:0]    p_left;
    logic [31:0]   p_shift;
    logic [31:0]   p_cookie;
    int unsigned   p_count;
    bit            p_done;
    dhcp_summary_t p_sum;

    dhcp_request_parser #(
        .MAX_MESSAGE_BYTES(MSG_LIMIT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic clear_parser();
        p_pos    = 0;
        p_phase  = WALK_CODE;
        p_code   = 8'h00;
        p_left   = 8'h00;
        p_shift  = 32'h0;
        p_cookie = 32'h0;
        p_count  = 0;
        p_done   = 1'b0;
        p_sum    = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        dhcp_summary_t want;
        dhcp_summary_t typed;
        bit            has_typed;
        if (p_pos < MSG_LIMIT)
        begin
            if (p_pos == 0)
                p_sum.op_code = b;
            else if (p_pos >= OFS_XID && p_pos <= OFS_XID_END)
                p_sum.transaction_id = {p_sum.transaction_id[23:0], b};
            else if (p_pos >= OFS_HW && p_pos <= OFS_HW_END)
                p_sum.client_hw_addr = {p_sum.client_hw_addr[39:0], b};
            else if (p_pos >= OFS_COOKIE && p_pos <= OFS_COOKIE_END)
            begin
                p_cookie = {p_cookie[23:0], b};
                if (p_pos == OFS_COOKIE_END && p_cookie == COOKIE)
                    p_sum.magic_ok = 1'b1;
            end
            else if (p_pos >= OFS_OPTIONS && p_sum.magic_ok && !p_done)
            begin
                case (p_phase)
                    WALK_CODE:
                    begin
                        if (b == OPT_END)
                            p_done = 1'b1;
                        else if (b != OPT_PAD)
                        begin
                            p_code  = b;
                            p_phase = WALK_LEN;
                        end
                    end
                    WALK_LEN:
                    begin
                        p_left  = b;
                        p_shift = 32'h0;
                        p_count = 0;
                        p_phase = (b == 8'h00) ? WALK_CODE : WALK_VALUE;
                    end
                    default:
                    begin
                        // Only the first four value bytes are kept, right aligned.
                        if (p_count < 4)
                        begin
                            p_shift = {p_shift[23:0], b};
                            p_count++;
                        end
                        p_left = p_left - 8'd1;
                        if (p_left == 8'h00)
                        begin
                            case (p_code)
                                OPT_MASK:     p_sum.subnet_mask    = p_shift;
                                OPT_ROUTER:   p_sum.router_addr    = p_shift;
                                OPT_DNS:      p_sum.dns_addr       = p_shift;
                                OPT_REQ_ADDR: p_sum.requested_addr = p_shift;
                                OPT_LEASE:    p_sum.lease_seconds  = p_shift;
                                OPT_SERVER:   p_sum.server_id      = p_shift;
                                OPT_MSG_TYPE: p_sum.message_type   =
                                    8'(p_shift >> (8 * (p_count - 1)));
                                default: ;
                            endcase
                            p_phase = WALK_CODE;
                        end
                    end
                endcase
            end
            p_pos++;
        end
        if (last)
        begin
            want = p_sum;
            want.reply_type = REPLY_NONE;
            if (p_sum.op_code == OP_REQUEST && p_sum.message_type == MT_DISCOVER)
                want.reply_type = REPLY_OFFER;
            else if (p_sum.op_code == OP_REQUEST && p_sum.message_type == MT_REQUEST)
                want.reply_type = REPLY_ACK;
            has_typed = typed_present.pop_front();
            typed = typed_summaries.pop_front();
            pending_summaries.push_back(has_typed ? typed : want);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got_v, want_v);
        failures++;
    endtask

    task automatic make_dhcp(ref logic [7:0] m [$], input logic [7:0] op,
                             input logic [31:0] cookie, input logic [7:0] opts [$],
                             input int total);
        m.delete();
        m.push_back(op);
        for (int k = 1; k < OFS_COOKIE; k++)
            m.push_back(8'($urandom_range(0, 255)));
        m.push_back(cookie[31:24]);
        m.push_back(cookie[23:16]);
        m.push_back(cookie[15:8]);
        m.push_back(cookie[7:0]);
        foreach (opts[k])
            m.push_back(opts[k]);
        while (m.size() < total)
            m.push_back(8'($urandom_range(0, 255)));
        if (total > 0 && m.size() > total)
            m = m[0:total-1];
    endtask

    task automatic queue_message(input logic [7:0] m [$], input bit typed,
                                 input dhcp_summary_t sum);
        stream_beat_t beat;
        typed_present.push_back(typed);
        typed_summaries.push_back(sum);
        foreach (m[k])
        begin
            beat.data = m[k];
            beat.last = (k == m.size() - 1);
            tx_q.push_back(beat);
        end
        bytes_queued += m.size();
    endtask

    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || pending_summaries.size() != 0)
            @(posedge clk);
    endtask

    // Prediction on every accepted input beat, checking on every result beat.
    always @(posedge clk)
    begin
        dhcp_summary_t got;
        dhcp_summary_t want;
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
        begin
            bytes_accepted++;
            parse_byte(s_tdata, s_tlast);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_summaries.size() == 0)
                report_mismatch("unexpected result beat", m_tdata[63:0], 64'h0);
            else
            begin
                want = pending_summaries.pop_front();
                got = dhcp_summary_t'(m_tdata[SUMMARY_W-1:0]);
                if (got.reply_type !== want.reply_type)
                    report_mismatch("reply_type", 64'(got.reply_type),
                                    64'(want.reply_type));
                if (got.magic_ok !== want.magic_ok)
                    report_mismatch("magic_ok", 64'(got.magic_ok), 64'(want.magic_ok));
                if (got.message_type !== want.message_type)
                    report_mismatch("message_type", 64'(got.message_type),
                                    64'(want.message_type));
                if (got.transaction_id !== want.transaction_id)
                    report_mismatch("transaction_id", 64'(got.transaction_id),
                                    64'(want.transaction_id));
                if (got.client_hw_addr !== want.client_hw_addr)
                    report_mismatch("client_hw_addr", 64'(got.client_hw_addr),
                                    64'(want.client_hw_addr));
                if (got.requested_addr !== want.requested_addr)
                    report_mismatch("requested_addr", 64'(got.requested_addr),
                                    64'(want.requested_addr));
                if (got.server_id !== want.server_id)
                    report_mismatch("server_id", 64'(got.server_id), 64'(want.server_id));
                if (got.lease_seconds !== want.lease_seconds)
                    report_mismatch("lease_seconds", 64'(got.lease_seconds),
                                    64'(want.lease_seconds));
                if (got.subnet_mask !== want.subnet_mask)
                    report_mismatch("subnet_mask", 64'(got.subnet_mask),
                                    64'(want.subnet_mask));
                if (got.router_addr !== want.router_addr)
                    report_mismatch("router_addr", 64'(got.router_addr),
                                    64'(want.router_addr));
                if (got.dns_addr !== want.dns_addr)
                    report_mismatch("dns_addr", 64'(got.dns_addr), 64'(want.dns_addr));
                if (got.op_code !== want.op_code)
                    report_mismatch("op_code", 64'(got.op_code), 64'(want.op_code));
                if (m_tdata[RESULT_W-1:SUMMARY_W] !== '0)
                    report_mismatch("zero fill", 64'(m_tdata[RESULT_W-1:SUMMARY_W]), 64'h0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("dhcp_request_parser test failed");
            $finish;
        end
    end

    // Sender: bursts of beats separated by gaps, a beat is held until taken.
    initial
    begin : sender
        stream_beat_t beat;
        int unsigned  burst_left;
        int unsigned  gap_left;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        burst_left = 1;
        gap_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!s_tvalid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (tx_q.size() > 0)
                begin
                    beat = tx_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= beat.data;
                    s_tlast  <= beat.last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall patterns, plus one long hold on request.
    initial
    begin : receiver
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned rx_mode;
        int unsigned tick;
        m_tready  = 1'b0;
        mode_left = 0;
        hold_left = 0;
        rx_mode   = 0;
        tick      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            tick++;
            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]    msg [$];
        logic [7:0]    opts [$];
        dhcp_summary_t typed;
        directed_row_t row;
        logic [31:0]   cookie;
        logic [7:0]    op;
        logic [7:0]    code;
        int            total;
        int            pick;
        int            n;
        int            len;
        int unsigned   directed_bytes;

        rst_n          = 1'b0;
        bytes_queued   = 0;
        bytes_accepted = 0;
        failures       = 0;
        idle_cycles    = 0;
        in_taken       = 1'b0;
        long_hold_req  = 1'b0;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            msg.delete();
            opts.delete();
            typed = '0;
            typed.op_code = row.op;
            typed.transaction_id = row.t_xid;
            cookie = COOKIE;
            case (row.which)
                CASE_DISCOVER:
                    opts = {OPT_MSG_TYPE, 8'd1, MT_DISCOVER, OPT_END};
                CASE_REQUEST:
                    opts = {OPT_MSG_TYPE, 8'd1, MT_REQUEST,
                            OPT_REQ_ADDR, 8'd4, 8'hc0, 8'ha8, 8'h01, 8'h64,
                            OPT_SERVER, 8'd4, 8'hc0, 8'ha8, 8'h01, 8'h01, OPT_END};
                CASE_ALL_VALUES:
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        opts.push_back(KEPT_CODES[k]);
                        opts.push_back(8'd4);
                        repeat (4) opts.push_back(row.fill);
                    end
                    opts.push_back(OPT_MSG_TYPE);
                    opts.push_back(8'd1);
                    opts.push_back(row.fill);
                    opts.push_back(OPT_END);
                end
                // Pads between options; everything after the end option is ignored.
                CASE_PADS_AND_END:
                    opts = {OPT_PAD, OPT_PAD, OPT_MSG_TYPE, 8'd1, MT_DISCOVER, OPT_PAD,
                            OPT_END, OPT_MSG_TYPE, 8'd1, MT_REQUEST,
                            OPT_REQ_ADDR, 8'd4, 8'h01, 8'h02, 8'h03, 8'h04};
                CASE_VALUE_LENGTHS:
                    opts = {OPT_LEASE, 8'd8, 8'h11, 8'h22, 8'h33, 8'h44,
                            8'h55, 8'h66, 8'h77, 8'h88,
                            OPT_MASK, 8'd2, 8'haa, 8'hbb, OPT_ROUTER, 8'd0,
                            OPT_DNS, 8'd1, 8'hcc, OPT_MSG_TYPE, 8'd0,
                            OPT_MSG_TYPE, 8'd2, MT_REQUEST, 8'h07, OPT_END};
                CASE_REPEATED:
                    opts = {OPT_REQ_ADDR, 8'd4, 8'h0a, 8'h00, 8'h00, 8'h01,
                            OPT_REQ_ADDR, 8'd4, 8'h0a, 8'h00, 8'h00, 8'h02,
                            OPT_MSG_TYPE, 8'd1, MT_REQUEST,
                            OPT_MSG_TYPE, 8'd1, MT_DISCOVER, OPT_END};
                // Unknown options whose values hold an end code and a known code.
                CASE_UNKNOWN:
                    opts = {8'h0c, 8'd3, OPT_END, OPT_MSG_TYPE, 8'd1, 8'h3d, 8'd0,
                            8'h52, 8'd5, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
                            OPT_MSG_TYPE, 8'd1, MT_REQUEST, OPT_END};
                CASE_CUT_BY_LAST:
                    opts = {OPT_MSG_TYPE, 8'd1, MT_REQUEST,
                            OPT_REQ_ADDR, 8'd4, 8'h01, 8'h02, 8'h03, 8'h04,
                            OPT_SERVER, 8'd4, 8'h05, 8'h06};
                // The lease value runs across the length limit and must not land.
                CASE_CUT_BY_LIMIT:
                begin
                    opts.push_back(8'h0c);
                    opts.push_back(8'd50);
                    repeat (50) opts.push_back(row.fill);
                    opts.push_back(OPT_LEASE);
                    opts.push_back(8'd20);
                    repeat (20) opts.push_back(row.fill);
                end
                CASE_BAD_COOKIE:
                begin
                    cookie = COOKIE ^ (32'h1 << $urandom_range(0, 31));
                    opts = {OPT_MSG_TYPE, 8'd1, MT_DISCOVER, OPT_END};
                end
                CASE_MT_LONG:
                    opts = {OPT_MSG_TYPE, 8'd5, MT_DISCOVER, 8'h09, 8'h09, 8'h09, 8'h09,
                            OPT_END};
                default: ;
            endcase
            if (row.which == CASE_FILL)
            begin
                msg.push_back(row.op);
                repeat (row.len - 1) msg.push_back(row.fill);
            end
            else
                make_dhcp(msg, row.op, cookie, opts, row.len);
            queue_message(msg, row.typed, typed);
        end

        // The sender stays quiet until every directed result is in.
        wait_drained();
        directed_bytes = bytes_queued;

        // A run of tiny messages while the receiver holds off fills the block.
        long_hold_req = 1'b1;
        repeat (10)
        begin
            msg.delete();
            repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(0, 255)));
            queue_message(msg, 1'b0, typed);
        end

        while (bytes_queued - directed_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            op = ($urandom_range(0, 3) != 0) ? OP_REQUEST : 8'($urandom_range(0, 255));
            opts.delete();
            n = $urandom_range(0, 8);
            for (int k = 0; k < n; k++)
            begin
                len = $urandom_range(0, 9);
                if (len < 7)
                    code = KEPT_CODES[len];
                else if (len == 7)
                    code = OPT_PAD;
                else
                    code = 8'($urandom_range(0, 255));
                opts.push_back(code);
                if (code != OPT_PAD)
                begin
                    if ($urandom_range(0, 5) == 0)
                        len = $urandom_range(0, 9);
                    else
                        len = (code == OPT_MSG_TYPE) ? 1 : 4;
                    opts.push_back(8'(len));
                    for (int j = 0; j < len; j++)
                    begin
                        if (code == OPT_MSG_TYPE && j == 0 && $urandom_range(0, 3) != 0)
                            opts.push_back($urandom_range(0, 1) ? MT_DISCOVER : MT_REQUEST);
                        else
                            opts.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            if ($urandom_range(0, 7) != 0)
                opts.push_back(OPT_END);
            cookie = COOKIE;
            total = $urandom_range(0, 1) ? 0 : OFS_OPTIONS + opts.size() + $urandom_range(0, 20);
            if (pick < 60)
                make_dhcp(msg, op, cookie, opts, total);
            else if (pick < 70)
                make_dhcp(msg, op, cookie ^ (32'h1 << $urandom_range(0, 31)), opts, total);
            else if (pick < 80)
                make_dhcp(msg, op, cookie, opts, $urandom_range(290, 340));
            else if (pick < 95)
            begin
                msg.delete();
                repeat ($urandom_range(1, 260)) msg.push_back(8'($urandom_range(0, 255)));
            end
            else
                make_dhcp(msg, op, cookie, opts, $urandom_range(1, 245));
            queue_message(msg, 1'b0, typed);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("dhcp_request_parser test passed");
        else
            $display("dhcp_request_parser test failed");
        $finish;
    end

endmodule
